// ----- hw/rtl/periodic_radial_bin_average_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the periodic radial bin average block
// Shared property shorthands; clk and rst_n are taken from the including scope.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_RADIAL_BIN_AVERAGE_DEFINES_SVH
`define PERIODIC_RADIAL_BIN_AVERAGE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/prba_pkg.sv -----
// ----------------------------------------------------------------------------
// prba_pkg
// Shared constants, codes and types of the periodic radial bin average block.
// ----------------------------------------------------------------------------
`default_nettype none

package prba_pkg;

  localparam int DEF_MAX_EDGE     = 32;
  localparam int DEF_BIN_COUNT    = 769;
  localparam int DEF_SAMPLE_WIDTH = 24;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 16;
  localparam int RSQ_W     = 10;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_ACCUM = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SCAN,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] size_x;
    logic [CFG_W-1:0] size_y;
    logic [CFG_W-1:0] size_z;
  } lattice_cfg_t;

  typedef struct packed {
    logic step;
    logic clear;
  } site_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/prba_ram.sv -----
// ----------------------------------------------------------------------------
// prba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module prba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/prba_site.sv -----
// ----------------------------------------------------------------------------
// prba_site
// Lattice site counter and periodic squared-distance bin index.
// ----------------------------------------------------------------------------
`default_nettype none

module prba_site #(
  parameter int MAX_EDGE  = 32,
  parameter int BIN_COUNT = 769
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prba_pkg::lattice_cfg_t       cfg,
  input  prba_pkg::site_ctl_t          ctl,
  output logic [$clog2(BIN_COUNT)-1:0] bin_idx
);

  import prba_pkg::*;

  localparam int POS_W = $clog2(MAX_EDGE);
  localparam int EXT_W = $clog2(MAX_EDGE + 1);
  localparam int CW    = (EXT_W > CFG_W) ? EXT_W : CFG_W;
  localparam int SQ_W  = 2 * EXT_W;
  localparam int R2_W  = SQ_W + 2;
  localparam int BW    = $clog2(BIN_COUNT);
  localparam int KW    = (R2_W > BW + 1) ? R2_W : BW + 1;

  function automatic logic [EXT_W-1:0] extent(input logic [CFG_W-1:0] s);
    logic [CW-1:0] w;
    w = CW'(s);
    if (w == '0) return EXT_W'(1);
    if (w > CW'(MAX_EDGE)) return EXT_W'(MAX_EDGE);
    return EXT_W'(w);
  endfunction

  // Distance to the nearer origin image; an out-of-extent coordinate counts as zero.
  function automatic logic [EXT_W-1:0] fold(input logic [POS_W-1:0] p,
                                            input logic [EXT_W-1:0] n);
    logic [EXT_W-1:0] c;
    logic [EXT_W-1:0] d;
    c = EXT_W'(p);
    if (c >= n) c = '0;
    d = n - c;
    return (c < d) ? c : d;
  endfunction

  logic [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [EXT_W-1:0] ext_x, ext_y, ext_z;
  logic [EXT_W-1:0] fx, fy, fz;
  logic [EXT_W-1:0] inc_x, inc_y, inc_z;
  logic             wrap_x, wrap_y, wrap_z;
  logic [SQ_W-1:0]  sq_x, sq_y, sq_z;
  logic [R2_W-1:0]  r2;

  assign ext_x = extent(cfg.size_x);
  assign ext_y = extent(cfg.size_y);
  assign ext_z = extent(cfg.size_z);

  assign fx = fold(pos_x_r, ext_x);
  assign fy = fold(pos_y_r, ext_y);
  assign fz = fold(pos_z_r, ext_z);

  assign sq_x = SQ_W'(fx) * SQ_W'(fx);
  assign sq_y = SQ_W'(fy) * SQ_W'(fy);
  assign sq_z = SQ_W'(fz) * SQ_W'(fz);
  assign r2   = R2_W'(sq_x) + R2_W'(sq_y) + R2_W'(sq_z);

  // Distances past the last bin land in it.
  assign bin_idx = (KW'(r2) >= KW'(BIN_COUNT)) ? BW'(BIN_COUNT - 1) : BW'(r2);

  assign inc_x  = EXT_W'(pos_x_r) + EXT_W'(1);
  assign inc_y  = EXT_W'(pos_y_r) + EXT_W'(1);
  assign inc_z  = EXT_W'(pos_z_r) + EXT_W'(1);
  assign wrap_x = inc_x >= ext_x;
  assign wrap_y = inc_y >= ext_y;
  assign wrap_z = inc_z >= ext_z;

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (ctl.clear) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
      pos_z_nxt = '0;
    end else if (ctl.step) begin
      pos_x_nxt = wrap_x ? '0 : POS_W'(inc_x);
      if (wrap_x) begin
        pos_y_nxt = wrap_y ? '0 : POS_W'(inc_y);
        if (wrap_y) begin
          pos_z_nxt = wrap_z ? '0 : POS_W'(inc_z);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/prba_div.sv -----
// ----------------------------------------------------------------------------
// prba_div
// Dual radix-2 restoring divider: two signed dividends over one unsigned
// divisor, quotients truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prba_div #(
  parameter int SUM_W = 40,
  parameter int QUO_W = 24,
  parameter int DEN_W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SUM_W-1:0]        num_a,
  input  logic [SUM_W-1:0]        num_b,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [QUO_W-1:0] quo_a,
  output logic signed [QUO_W-1:0] quo_b
);

  localparam int IT_W = $clog2(SUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic [SUM_W-1:0] qa_r, qb_r;
  logic [DEN_W-1:0] ra_r, rb_r, den_r;
  logic             neg_a_r, neg_b_r;

  logic [DEN_W:0]   sh_a, sh_b, diff_a, diff_b;
  logic             ge_a, ge_b;
  logic [SUM_W-1:0] abs_a, abs_b, mag_a, mag_b;

  assign abs_a = num_a[SUM_W-1] ? (~num_a + SUM_W'(1)) : num_a;
  assign abs_b = num_b[SUM_W-1] ? (~num_b + SUM_W'(1)) : num_b;

  assign sh_a   = {ra_r, qa_r[SUM_W-1]};
  assign sh_b   = {rb_r, qb_r[SUM_W-1]};
  assign diff_a = sh_a - {1'b0, den_r};
  assign diff_b = sh_b - {1'b0, den_r};
  assign ge_a   = sh_a >= {1'b0, den_r};
  assign ge_b   = sh_b >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = IT_W'(SUM_W);
    end else if (busy_r) begin
      it_nxt = it_r - IT_W'(1);
      if (it_r == IT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qa_r    <= abs_a;
      qb_r    <= abs_b;
      ra_r    <= '0;
      rb_r    <= '0;
      den_r   <= den;
      neg_a_r <= num_a[SUM_W-1];
      neg_b_r <= num_b[SUM_W-1];
    end else if (busy_r) begin
      qa_r <= {qa_r[SUM_W-2:0], ge_a};
      qb_r <= {qb_r[SUM_W-2:0], ge_b};
      ra_r <= ge_a ? diff_a[DEN_W-1:0] : sh_a[DEN_W-1:0];
      rb_r <= ge_b ? diff_b[DEN_W-1:0] : sh_b[DEN_W-1:0];
    end
  end

  assign mag_a = neg_a_r ? (~qa_r + SUM_W'(1)) : qa_r;
  assign mag_b = neg_b_r ? (~qb_r + SUM_W'(1)) : qb_r;

  assign done  = done_r;
  assign quo_a = signed'(mag_a[QUO_W-1:0]);
  assign quo_b = signed'(mag_b[QUO_W-1:0]);

endmodule

`default_nettype wire

// ----- hw/rtl/periodic_radial_bin_average.sv -----
// ----------------------------------------------------------------------------
// periodic_radial_bin_average
// Streams complex lattice samples in x-fastest order into bins keyed by the
// periodic squared distance of each site from the origin, and drains the
// nonempty bins one per command as (r^2, mean real, mean imag, count, last).
// Accumulate transactions sustain one per cycle: each is a read-modify-write
// of one bin entry in a single bin RAM, with a one-deep forward of the
// previous write so back-to-back hits on the same bin add up correctly. A
// drain transaction scans the bin RAM one entry per cycle from the drain
// pointer until it has found the bin to emit and the next nonempty bin after
// it, or reaches the last bin; for a found bin it then runs a shared
// bit-serial divider for the two means. After the final bin of a drain, or
// an empty drain, the RAM is cleared by a sweep over all BIN_COUNT entries
// (769 by default); the same sweep runs after reset. No input transaction
// is taken during a drain or a sweep; configuration writes are taken at any
// time but are meant for an idle block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_radial_bin_average_defines.svh"

module periodic_radial_bin_average #(
  parameter int MAX_EDGE     = prba_pkg::DEF_MAX_EDGE,
  parameter int BIN_COUNT    = prba_pkg::DEF_BIN_COUNT,
  parameter int SAMPLE_WIDTH = prba_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input transactions
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample_imag,
  // result transactions
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [prba_pkg::RSQ_W-1:0]       out_radius_squared,
  output logic signed [SAMPLE_WIDTH-1:0]   out_average_real,
  output logic signed [SAMPLE_WIDTH-1:0]   out_average_imag,
  output logic [prba_pkg::COUNT_W-1:0]     out_site_count,
  output logic                             out_last_bin,
  output logic                             out_nothing_left,
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic [prba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prba_pkg::CFG_W-1:0]       cfg_wdata
);

  import prba_pkg::*;

  localparam int BIN_W = $clog2(BIN_COUNT);
  localparam int PTR_W = $clog2(BIN_COUNT + 1);
  localparam int SUM_W = SAMPLE_WIDTH + COUNT_W;
  localparam int ENT_W = 2 * SUM_W + COUNT_W;

  localparam logic [BIN_W-1:0]   LAST_BIN = BIN_W'(BIN_COUNT - 1);
  localparam logic [PTR_W-1:0]   PTR_END  = PTR_W'(BIN_COUNT);
  localparam logic [COUNT_W-1:0] CNT_MAX  = {COUNT_W{1'b1}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  lattice_cfg_t lat_r, lat_nxt;

  always_comb begin
    lat_nxt = lat_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: lat_nxt.size_x = cfg_wdata;
        REG_SIZE_Y: lat_nxt.size_y = cfg_wdata;
        REG_SIZE_Z: lat_nxt.size_z = cfg_wdata;
        default:    ;  // no register at this index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [BIN_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [BIN_W-1:0]  drain_ptr_r, drain_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [BIN_W-1:0]  chk_addr_r;
  logic              found_r, found_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;

  // accumulate write-back stage and forward of the previous write
  logic              acc_v_r;
  logic [BIN_W-1:0]  acc_addr_r;
  logic [SAMPLE_WIDTH-1:0] acc_re_r, acc_im_r;
  logic              fwd_v_r;
  logic [BIN_W-1:0]  fwd_addr_r;
  logic [ENT_W-1:0]  fwd_data_r;

  // bin captured by the scan
  logic [BIN_W-1:0]   hold_addr_r;
  logic [SUM_W-1:0]   hold_re_r, hold_im_r;
  logic [COUNT_W-1:0] hold_cnt_r;

  // result register
  logic [RSQ_W-1:0]               out_rsq_r;
  logic signed [SAMPLE_WIDTH-1:0] out_re_r, out_im_r;
  logic [COUNT_W-1:0]             out_cnt_r;
  logic                           out_last_r, out_none_r;

  // --------------------------------------------------------------------------
  // Datapath nets
  // --------------------------------------------------------------------------
  logic               in_accept, acc_go, drain_go;
  logic [BIN_W-1:0]   bin_idx;
  site_ctl_t          site_ctl;
  logic               site_clear;

  logic               ram_we;
  logic [BIN_W-1:0]   ram_waddr, ram_raddr;
  logic [ENT_W-1:0]   ram_wdata, ram_rdata;

  logic [ENT_W-1:0]   cur_ent, new_ent;
  logic [SUM_W-1:0]   cur_re, cur_im;
  logic [COUNT_W-1:0] cur_cnt;

  logic [SUM_W-1:0]   rd_re, rd_im;
  logic [COUNT_W-1:0] rd_cnt;
  logic               hit, at_end, capture, scan_done, scan_empty, scan_issue;

  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_num_re, div_num_im;
  logic [COUNT_W-1:0] div_den;
  logic signed [SAMPLE_WIDTH-1:0] div_quo_re, div_quo_im;

  logic               out_load, out_empty;

  assign in_accept = in_valid && !in_stall;
  assign acc_go    = in_accept && (in_command == CMD_ACCUM);
  assign drain_go  = in_accept && (in_command == CMD_DRAIN);

  // --------------------------------------------------------------------------
  // Site tracking: advance on every accumulate, return to origin on a sweep
  // --------------------------------------------------------------------------
  assign site_ctl.step  = acc_go;
  assign site_ctl.clear = site_clear;

  prba_site #(
    .MAX_EDGE  (MAX_EDGE),
    .BIN_COUNT (BIN_COUNT)
  ) u_site (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (lat_r),
    .ctl     (site_ctl),
    .bin_idx (bin_idx)
  );

  // --------------------------------------------------------------------------
  // Bin RAM: {sum_real, sum_imag, count} per entry
  // --------------------------------------------------------------------------
  prba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rd_data (ram_rdata)
  );

  // The scan owns the read port while scanning; otherwise the read follows the
  // current site so an accepted sample has its bin in hand in the next cycle.
  assign ram_raddr = (state_r == ST_SCAN) ? rd_ptr_r[BIN_W-1:0] : bin_idx;

  // Write-back: the RAM returns data that is one write stale when the bin
  // written last cycle is the one read now, so take the forwarded copy then.
  always_comb begin
    cur_ent = (fwd_v_r && (fwd_addr_r == acc_addr_r)) ? fwd_data_r : ram_rdata;
    cur_re  = cur_ent[ENT_W-1 -: SUM_W];
    cur_im  = cur_ent[COUNT_W +: SUM_W];
    cur_cnt = cur_ent[COUNT_W-1:0];
    if (cur_cnt == CNT_MAX) begin
      // saturated bin: hold as is
      new_ent = cur_ent;
    end else begin
      new_ent = {cur_re + {{COUNT_W{acc_re_r[SAMPLE_WIDTH-1]}}, acc_re_r},
                 cur_im + {{COUNT_W{acc_im_r[SAMPLE_WIDTH-1]}}, acc_im_r},
                 cur_cnt + COUNT_W'(1)};
    end
  end

  assign ram_we    = acc_v_r || (state_r == ST_CLEAR);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : acc_addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : new_ent;

  // --------------------------------------------------------------------------
  // Scan check: data for chk_addr_r arrives in the cycle after its read
  // --------------------------------------------------------------------------
  assign rd_re  = ram_rdata[ENT_W-1 -: SUM_W];
  assign rd_im  = ram_rdata[COUNT_W +: SUM_W];
  assign rd_cnt = ram_rdata[COUNT_W-1:0];

  assign hit        = chk_v_r && (rd_cnt != '0);
  assign at_end     = chk_v_r && (chk_addr_r == LAST_BIN);
  assign capture    = hit && !found_r;
  // Stop at the second nonempty bin, or at the top of the RAM.
  assign scan_done  = (hit && found_r) || at_end;
  assign scan_empty = at_end && !hit && !found_r;

  // --------------------------------------------------------------------------
  // Mean division
  // --------------------------------------------------------------------------
  // When the bin is found on the top entry, the divider starts in the same
  // cycle as the capture: feed it the RAM data directly then.
  assign div_num_re = capture ? rd_re  : hold_re_r;
  assign div_num_im = capture ? rd_im  : hold_im_r;
  assign div_den    = capture ? rd_cnt : hold_cnt_r;

  prba_div #(
    .SUM_W (SUM_W),
    .QUO_W (SAMPLE_WIDTH),
    .DEN_W (COUNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_a (div_num_re),
    .num_b (div_num_im),
    .den   (div_den),
    .done  (div_done),
    .quo_a (div_quo_re),
    .quo_b (div_quo_im)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_BIN) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (drain_go) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = scan_empty ? ST_CLEAR : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = last_r ? ST_CLEAR : ST_RUN;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs and counters
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall      = 1'b1;
    site_clear    = 1'b0;
    scan_issue    = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_empty     = 1'b0;
    clr_addr_nxt  = '0;
    drain_ptr_nxt = drain_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    chk_v_nxt     = 1'b0;
    found_nxt     = found_r;
    last_nxt      = last_r;
    unique case (state_r)
      ST_CLEAR: begin
        site_clear    = 1'b1;
        drain_ptr_nxt = '0;
        if (clr_addr_r != LAST_BIN) clr_addr_nxt = clr_addr_r + BIN_W'(1);
      end
      ST_RUN: begin
        // Samples flow freely; a drain waits until the result slot is empty.
        in_stall   = (in_command == CMD_DRAIN) && out_valid_r;
        rd_ptr_nxt = PTR_W'(drain_ptr_r);
        found_nxt  = 1'b0;
      end
      ST_SCAN: begin
        scan_issue = rd_ptr_r != PTR_END;
        chk_v_nxt  = scan_issue && !scan_done;
        if (scan_issue) rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
        if (capture) found_nxt = 1'b1;
        if (scan_done) begin
          // last when the top was reached with exactly one nonempty bin seen
          last_nxt = found_r ^ hit;
          if (scan_empty) begin
            out_load  = 1'b1;
            out_empty = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          out_load = 1'b1;
          if (!last_r) drain_ptr_nxt = hold_addr_r + BIN_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r       <= '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      drain_ptr_r <= '0;
      rd_ptr_r    <= '0;
      chk_v_r     <= 1'b0;
      found_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_v_r     <= 1'b0;
      fwd_v_r     <= 1'b0;
    end else begin
      lat_r       <= lat_nxt;
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      drain_ptr_r <= drain_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      chk_v_r     <= chk_v_nxt;
      found_r     <= found_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      acc_v_r     <= acc_go;
      fwd_v_r     <= acc_v_r;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    acc_addr_r <= bin_idx;
    acc_re_r   <= in_sample_real;
    acc_im_r   <= in_sample_imag;
    fwd_addr_r <= acc_addr_r;
    fwd_data_r <= new_ent;
    chk_addr_r <= rd_ptr_r[BIN_W-1:0];
    if (capture) begin
      hold_addr_r <= chk_addr_r;
      hold_re_r   <= rd_re;
      hold_im_r   <= rd_im;
      hold_cnt_r  <= rd_cnt;
    end
    if (out_load) begin
      out_rsq_r  <= out_empty ? '0 : RSQ_W'(hold_addr_r);
      out_re_r   <= out_empty ? '0 : div_quo_re;
      out_im_r   <= out_empty ? '0 : div_quo_im;
      out_cnt_r  <= out_empty ? '0 : hold_cnt_r;
      out_last_r <= out_empty ? 1'b0 : last_r;
      out_none_r <= out_empty;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_radius_squared = out_rsq_r;
  assign out_average_real   = out_re_r;
  assign out_average_imag   = out_im_r;
  assign out_site_count     = out_cnt_r;
  assign out_last_bin       = out_last_r;
  assign out_nothing_left   = out_none_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PRBA_ASSERT_SAME(a_load_free, out_load, !out_valid_r, "result overwrites a pending transaction")
  `PRBA_ASSERT_SAME(a_wb_in_run, acc_v_r, state_r == ST_RUN, "bin write-back outside run state")
  `PRBA_ASSERT_NEXT(a_div_enter, div_start, state_r == ST_DIV, "divider started without entering divide")
  `PRBA_ASSERT_SAME(a_div_done, div_done, state_r == ST_DIV, "divider finished outside divide state")
  `PRBA_ASSERT_SAME(a_found_cnt, found_r, hold_cnt_r != '0, "captured bin has zero count")

endmodule

`default_nettype wire
